FILE: src/bsie_pkg.sv
package bsie_pkg;

	localparam logic [5:0] OP_LD  = 6'd24;
	localparam logic [5:0] OP_ST  = 6'd25;
	localparam logic [5:0] OP_JMP = 6'd27;
	localparam logic [5:0] OP_BEQ = 6'd29;
	localparam logic [5:0] OP_BNE = 6'd30;
	localparam logic [5:0] OP_LDR = 6'd31;

	localparam logic [3:0] FN_ADD   = 4'd0;
	localparam logic [3:0] FN_SUB   = 4'd1;
	localparam logic [3:0] FN_MUL   = 4'd2;
	localparam logic [3:0] FN_DIV   = 4'd3;
	localparam logic [3:0] FN_CMPEQ = 4'd4;
	localparam logic [3:0] FN_CMPLT = 4'd5;
	localparam logic [3:0] FN_CMPLE = 4'd6;
	localparam logic [3:0] FN_AND   = 4'd8;
	localparam logic [3:0] FN_OR    = 4'd9;
	localparam logic [3:0] FN_XOR   = 4'd10;
	localparam logic [3:0] FN_SHL   = 4'd12;
	localparam logic [3:0] FN_SHR   = 4'd13;
	localparam logic [3:0] FN_SRA   = 4'd14;

	localparam logic [31:0] JMP_MASK = 32'hffff_fffc;

	// request to the shared multiply / divide unit
	typedef struct packed {
		logic        start;
		logic        is_div;
		logic [31:0] a;
		logic [31:0] b;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic        dz;
		logic [31:0] result;
	} md_rsp_t;

	// true for opcodes the ALU group implements
	function automatic logic fn_legal(input logic [3:0] fn);
		logic ok;
		begin
			ok = !(fn == 4'd7 || fn == 4'd11 || fn == 4'd15);
			return ok;
		end
	endfunction

endpackage

FILE: src/bsie_muldiv.sv
// Shift-add multiplier and restoring divider, one bit per cycle.
module bsie_muldiv (
	input  logic            clk,
	input  logic            arst_n,
	input  bsie_pkg::md_req_t req,
	output bsie_pkg::md_rsp_t rsp
);
	import bsie_pkg::*;

	logic        busy_q;
	logic        div_q;
	logic [5:0]  cnt_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] acc_q;
	logic [31:0] quo_q;
	logic        dz_q;
	logic        done_q;

	logic [32:0] rem_shift;
	logic [32:0] rem_sub;

	always_comb begin
		rem_shift = {acc_q, a_q[31]};
		rem_sub   = rem_shift - {1'b0, b_q};
	end

	// iterate one bit per cycle over all 32 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == 6'd31);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
			quo_q <= '0;
			dz_q  <= (req.b == '0);
		end else if (busy_q) begin
			if (div_q) begin
				// restoring division step
				a_q <= {a_q[30:0], 1'b0};
				if (!rem_sub[32]) begin
					acc_q <= rem_sub[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					acc_q <= rem_shift[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end else begin
				// shift-add multiply, low 32 bits only
				if (b_q[0])
					acc_q <= acc_q + a_q;
				a_q <= {a_q[30:0], 1'b0};
				b_q <= {1'b0, b_q[31:1]};
			end
		end
	end

	always_comb begin
		rsp.done   = done_q;
		rsp.dz     = div_q && dz_q;
		if (div_q)
			rsp.result = dz_q ? 32'hffff_ffff : quo_q;
		else
			rsp.result = acc_q;
	end

endmodule

FILE: src/beta_style_instruction_executor.sv
// Each instruction runs READ, EXEC, then LOAD for LD / LDR or the shared multiply /
// divide unit for MUL / DIV (one bit per cycle), then OUT; the result is valid in OUT.
// One instruction at a time; OUT holds the result through output stalls, and the next
// instruction is accepted the cycle after the result transfer.
// After reset a clearing pass writes zero to every data word, with ready low.
// Asynchronous active-low reset clears PC, registers, control.
module beta_style_instruction_executor #(
	parameter int DATA_WORDS    = 256,
	parameter int PROGRAM_WORDS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	output logic        ready_in,
	input  logic [31:0] instruction,
	output logic        valid_out,
	input  logic        ready_out,
	output logic [7:0]  next_pc,
	output logic        reg_write,
	output logic [4:0]  reg_index,
	output logic [31:0] reg_value,
	output logic        mem_write,
	output logic [7:0]  mem_address,
	output logic [31:0] mem_value,
	output logic        illegal,
	output logic        divide_fault
);
	import bsie_pkg::*;

	localparam int DW = $clog2(DATA_WORDS);
	localparam int PW = $clog2(PROGRAM_WORDS);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_EXEC  = 3'd3;
	localparam logic [2:0] ST_MD    = 3'd4;
	localparam logic [2:0] ST_LOAD  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]    state_q;
	logic [DW:0]   clr_q;
	logic [PW-1:0] pc_q;
	logic [31:0]   ins_q;
	logic [31:0]   va_q;
	logic [31:0]   vb_q;
	logic [31:0]   rf_q [32];
	logic [31:0]   dmem [DATA_WORDS];
	logic [31:0]   dout_q;

	logic [5:0]  op;
	logic [4:0]  rc;
	logic [4:0]  ra;
	logic [4:0]  rb;
	logic [31:0] lit;
	assign op  = ins_q[31:26];
	assign rc  = ins_q[25:21];
	assign ra  = ins_q[20:16];
	assign rb  = ins_q[15:11];
	assign lit = {16'd0, ins_q[15:0]};

	// result registers
	logic [PW-1:0] npc_q;
	logic          wreg_q;
	logic [31:0]   rval_q;
	logic          wmem_q;
	logic [DW-1:0] maddr_q;
	logic [31:0]   mval_q;
	logic          ill_q;
	logic          dz_q;

	md_req_t md_req;
	md_rsp_t md_rsp;

	bsie_muldiv u_md (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.rsp   (md_rsp)
	);

	// execute-stage decode
	logic [PW-1:0] inc;
	logic [31:0]   opb;
	logic [4:0]    sh;
	logic [31:0]   alu_r;
	logic [31:0]   ea;
	logic [DW-1:0] ld_addr;
	assign inc = pc_q + PW'(1);
	assign opb = op[4] ? lit : vb_q;
	assign sh  = opb[4:0];
	assign ea  = va_q + lit;
	// data address for LD / ST / LDR, valid during EXEC
	assign ld_addr = (op == OP_LDR) ? DW'(32'(inc) + lit) : ea[DW-1:0];

	always_comb begin
		unique case (op[3:0])
			FN_ADD:   alu_r = va_q + opb;
			FN_SUB:   alu_r = va_q - opb;
			FN_CMPEQ: alu_r = {31'd0, va_q == opb};
			FN_CMPLT: alu_r = {31'd0, va_q < opb};
			FN_CMPLE: alu_r = {31'd0, va_q <= opb};
			FN_AND:   alu_r = va_q & opb;
			FN_OR:    alu_r = va_q | opb;
			FN_XOR:   alu_r = va_q ^ opb;
			FN_SHL:   alu_r = va_q << sh;
			FN_SHR:   alu_r = va_q >> sh;
			FN_SRA:   alu_r = $unsigned($signed(va_q) >>> sh);
			default:  alu_r = '0;
		endcase
	end

	// result fields computed in EXEC
	logic [PW-1:0] x_npc;
	logic          x_wreg;
	logic [31:0]   x_rval;
	logic          x_wmem;
	logic [DW-1:0] x_maddr;
	logic          x_ill;

	always_comb begin
		x_npc   = inc;
		x_wreg  = 1'b0;
		x_rval  = '0;
		x_wmem  = 1'b0;
		x_maddr = '0;
		x_ill   = 1'b0;
		priority if (op == OP_LD) begin
			x_maddr = ld_addr;
			x_wreg  = 1'b1;
		end else if (op == OP_ST) begin
			x_maddr = ld_addr;
			x_wmem  = 1'b1;
		end else if (op == OP_JMP) begin
			x_wreg = 1'b1;
			x_rval = 32'(inc);
			x_npc  = PW'(va_q & JMP_MASK);
		end else if (op == OP_BEQ || op == OP_BNE) begin
			x_wreg = 1'b1;
			x_rval = 32'(inc);
			if ((op == OP_BEQ) == (va_q == '0))
				x_npc = inc + lit[PW-1:0];
		end else if (op == OP_LDR) begin
			x_maddr = ld_addr;
			x_wreg  = 1'b1;
		end else if (op[5] && fn_legal(op[3:0])) begin
			x_wreg = 1'b1;
			x_rval = alu_r;
		end else begin
			x_ill = 1'b1;
			x_npc = pc_q;
		end
	end

	always_comb begin
		md_req.start  = (state_q == ST_EXEC) && op[5] &&
			(op[3:0] == FN_MUL || op[3:0] == FN_DIV);
		md_req.is_div = (op[3:0] == FN_DIV);
		md_req.a      = va_q;
		md_req.b      = opb;
	end

	assign ready_in  = (state_q == ST_IDLE);
	assign valid_out = (state_q == ST_OUT);

	// data memory: clearing pass, store, registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR)
			dmem[clr_q[DW-1:0]] <= '0;
		else if (state_q == ST_OUT && ready_out && wmem_q)
			dmem[maddr_q] <= mval_q;
		dout_q <= dmem[ld_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			pc_q    <= '0;
			for (int i = 0; i < 32; i++)
				rf_q[i] <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + (DW+1)'(1);
					if (clr_q == (DW+1)'(DATA_WORDS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (valid_in)
						state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (md_req.start)
						state_q <= ST_MD;
					else if (op == OP_LD || op == OP_LDR)
						state_q <= ST_LOAD;
					else
						state_q <= ST_OUT;
				end
				ST_MD: begin
					if (md_rsp.done)
						state_q <= ST_OUT;
				end
				ST_LOAD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (ready_out) begin
						state_q <= ST_IDLE;
						if (!ill_q) begin
							pc_q <= npc_q;
							if (wreg_q)
								rf_q[rc] <= rval_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ins_q <= instruction;
			end
			ST_READ: begin
				va_q   <= rf_q[ra];
				vb_q   <= rf_q[rb];
				mval_q <= rf_q[rc];
			end
			ST_EXEC: begin
				npc_q   <= x_npc;
				wreg_q  <= x_wreg;
				rval_q  <= x_rval;
				wmem_q  <= x_wmem;
				maddr_q <= x_maddr;
				ill_q   <= x_ill;
				dz_q    <= 1'b0;
			end
			ST_MD: begin
				if (md_rsp.done) begin
					rval_q <= md_rsp.result;
					dz_q   <= md_rsp.dz;
				end
			end
			ST_LOAD: begin
				rval_q <= dout_q;
			end
			default: begin
			end
		endcase
	end

	// output fields
	assign next_pc      = 8'(npc_q);
	assign reg_write    = wreg_q;
	assign reg_index    = wreg_q ? rc : 5'd0;
	assign reg_value    = rval_q;
	assign mem_write    = wmem_q;
	assign mem_address  = 8'(maddr_q);
	assign mem_value    = wmem_q ? mval_q : 32'd0;
	assign illegal      = ill_q;
	assign divide_fault = dz_q;

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ready_in && valid_out)) else $error("ready and result valid together");
	a_ill_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && illegal |-> !reg_write && !mem_write && !divide_fault)
		else $error("illegal op changed state");
	a_ill_pc: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && illegal |-> next_pc == 8'(pc_q))
		else $error("illegal op moved pc");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && ready_out |=> !valid_out) else $error("result repeated");
`endif

endmodule

FILE: tb/beta_style_instruction_executor_test.sv
`timescale 1ns / 100ps

module beta_style_instruction_executor_test;
	import bsie_pkg::*;

	localparam int MEM_WORDS = 256;
	localparam int PC_WORDS  = 256;

	typedef struct packed {
		logic [7:0]  next_pc;
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic        mem_write;
		logic [7:0]  mem_address;
		logic [31:0] mem_value;
		logic        illegal;
		logic        divide_fault;
	} exec_result_t;

	logic        clk;
	logic        arst_n;
	logic        valid_in;
	logic        ready_in;
	logic [31:0] instruction;
	logic        valid_out;
	logic        ready_out;
	logic [7:0]  next_pc;
	logic        reg_write;
	logic [4:0]  reg_index;
	logic [31:0] reg_value;
	logic        mem_write;
	logic [7:0]  mem_address;
	logic [31:0] mem_value;
	logic        illegal;
	logic        divide_fault;

	// predictor state
	logic [7:0]  arch_pc;
	logic [31:0] arch_regs [32];
	logic [31:0] arch_mem [MEM_WORDS];

	exec_result_t pending_results[$];
	int mismatch_count;
	int result_count;
	int sent_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;

	beta_style_instruction_executor u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_in     (valid_in),
		.ready_in     (ready_in),
		.instruction  (instruction),
		.valid_out    (valid_out),
		.ready_out    (ready_out),
		.next_pc      (next_pc),
		.reg_write    (reg_write),
		.reg_index    (reg_index),
		.reg_value    (reg_value),
		.mem_write    (mem_write),
		.mem_address  (mem_address),
		.mem_value    (mem_value),
		.illegal      (illegal),
		.divide_fault (divide_fault)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ALU function for the register and literal groups
	function automatic logic [31:0] alu_eval(input logic [3:0] fn, input logic [31:0] a,
			input logic [31:0] b, output logic ok, output logic dz);
		logic [4:0] sh;
		sh = b[4:0];
		ok = 1'b1;
		dz = 1'b0;
		case (fn)
			FN_ADD:   return a + b;
			FN_SUB:   return a - b;
			FN_MUL:   return a * b;
			FN_DIV: begin
				if (b == 32'd0) begin
					dz = 1'b1;
					return 32'hffff_ffff;
				end
				return a / b;
			end
			FN_CMPEQ: return {31'd0, a == b};
			FN_CMPLT: return {31'd0, a < b};
			FN_CMPLE: return {31'd0, a <= b};
			FN_AND:   return a & b;
			FN_OR:    return a | b;
			FN_XOR:   return a ^ b;
			FN_SHL:   return a << sh;
			FN_SHR:   return a >> sh;
			FN_SRA:   return $unsigned($signed(a) >>> sh);
			default: begin
				ok = 1'b0;
				return 32'd0;
			end
		endcase
	endfunction

	// executes one instruction on the predictor state, returns the expected result
	function automatic exec_result_t execute_instruction(input logic [31:0] ins);
		exec_result_t r;
		logic [5:0]  op;
		logic [4:0]  rc, ra, rb;
		logic [31:0] lit, va, b, inc, npc, rval, mval, sum;
		logic [7:0]  maddr;
		logic wreg, wmem, ill, dz, ok;
		op = ins[31:26];
		rc = ins[25:21];
		ra = ins[20:16];
		rb = ins[15:11];
		lit = {16'd0, ins[15:0]};
		va = arch_regs[ra];
		inc = (arch_pc + 32'd1) % PC_WORDS;
		npc = inc;
		wreg = 1'b0; wmem = 1'b0; ill = 1'b0; dz = 1'b0;
		rval = 32'd0; mval = 32'd0; maddr = 8'd0;
		case (op)
			OP_LD: begin
				sum = va + lit;
				maddr = 8'(sum % MEM_WORDS);
				wreg = 1'b1;
				rval = arch_mem[maddr];
			end
			OP_ST: begin
				sum = va + lit;
				maddr = 8'(sum % MEM_WORDS);
				wmem = 1'b1;
				mval = arch_regs[rc];
			end
			OP_JMP: begin
				wreg = 1'b1;
				rval = inc;
				npc = (va & JMP_MASK) % PC_WORDS;
			end
			OP_BEQ, OP_BNE: begin
				wreg = 1'b1;
				rval = inc;
				if ((op == OP_BEQ) == (va == 32'd0))
					npc = (inc + lit) % PC_WORDS;
			end
			OP_LDR: begin
				maddr = 8'((inc + lit) % MEM_WORDS);
				wreg = 1'b1;
				rval = arch_mem[maddr];
			end
			default: begin
				if (op[5]) begin
					b = op[4] ? lit : arch_regs[rb];
					rval = alu_eval(op[3:0], va, b, ok, dz);
					if (ok)
						wreg = 1'b1;
					else
						ill = 1'b1;
				end else begin
					ill = 1'b1;
				end
			end
		endcase
		if (ill) begin
			npc = arch_pc;
			rval = 32'd0;
			dz = 1'b0;
		end else begin
			arch_pc = npc[7:0];
			if (wmem)
				arch_mem[maddr] = mval;
			if (wreg)
				arch_regs[rc] = rval;
		end
		r.next_pc = npc[7:0];
		r.reg_write = wreg;
		r.reg_index = wreg ? rc : 5'd0;
		r.reg_value = wreg ? rval : 32'd0;
		r.mem_write = wmem;
		r.mem_address = maddr;
		r.mem_value = mval;
		r.illegal = ill;
		r.divide_fault = dz;
		return r;
	endfunction

	// sends one instruction, with random idle cycles first; valid stays high after
	// the transfer until the next idle cycle or the drain
	task automatic send_instruction(input logic [31:0] ins);
		while ($urandom_range(99) < send_idle_pct) begin
			valid_in <= 1'b0;
			@(posedge clk);
		end
		valid_in <= 1'b1;
		instruction <= ins;
		@(posedge clk);
		while (!ready_in)
			@(posedge clk);
		pending_results.push_back(execute_instruction(ins));
		sent_count++;
	endtask

	task automatic wait_drained();
		valid_in <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] make_ins(input logic [5:0] op, input logic [4:0] rc,
			input logic [4:0] ra, input logic [15:0] lo);
		return {op, rc, ra, lo};
	endfunction

	// receiver stall pattern, with an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_out <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			ready_out <= 1'b0;
		end else begin
			ready_out <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		exec_result_t got, want;
		if (arst_n && valid_out && ready_out) begin
			got = '{next_pc, reg_write, reg_index, reg_value, mem_write, mem_address,
				mem_value, illegal, divide_fault};
			result_count++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected result transfer: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch at result %0d:\n  expected %p\n  actual   %p",
							result_count, want, got);
				end
			end
		end
	end

	// edge values of registers, the memory and branch opcodes, and every third opcode, including unused ones
	task automatic test_directed();
		int op;
		send_instruction(make_ins(6'd48, 5'd1, 5'd31, 16'hffff));
		send_instruction(make_ins(6'd60, 5'd1, 5'd1, 16'd16));
		send_instruction(make_ins(6'd57, 5'd1, 5'd1, 16'hffff));
		send_instruction(make_ins(6'd62, 5'd2, 5'd1, 16'd31));
		send_instruction(make_ins(6'd62, 5'd3, 5'd1, 16'd0));
		send_instruction(make_ins(6'd35, 5'd4, 5'd1, 16'd0));
		send_instruction(make_ins(6'd51, 5'd5, 5'd1, 16'd0));
		send_instruction(make_ins(6'd46, 5'd6, 5'd1, 16'hffff));
		send_instruction(make_ins(6'd44, 5'd7, 5'd1, 16'h0800));
		send_instruction(make_ins(OP_ST, 5'd1, 5'd31, 16'hffff));
		send_instruction(make_ins(OP_LD, 5'd31, 5'd31, 16'hffff));
		send_instruction(make_ins(OP_LDR, 5'd8, 5'd0, 16'hfff0));
		send_instruction(make_ins(OP_BEQ, 5'd9, 5'd0, 16'hffff));
		send_instruction(make_ins(OP_BNE, 5'd9, 5'd1, 16'd5));
		send_instruction(make_ins(OP_JMP, 5'd10, 5'd1, 16'd0));
		send_instruction(make_ins(6'd34, 5'd1, 5'd1, 16'h0800));
		for (op = 0; op < 64; op += 3)
			send_instruction(make_ins(op[5:0], 5'd31, 5'd31, 16'h8421));
		send_instruction(32'hffff_ffff);
		send_instruction(32'h0000_0000);
	endtask

	// one random instruction; mostly legal with interesting operands
	function automatic logic [31:0] random_instruction();
		logic [5:0] op;
		logic [15:0] lo;
		case ($urandom_range(9))
			0: op = 6'($urandom_range(63));
			1, 2: op = OP_LD + 6'($urandom_range(7));
			default: op = 6'd32 + 6'($urandom_range(31));
		endcase
		case ($urandom_range(3))
			0: lo = 16'($urandom_range(31));
			1: lo = 16'hffff - 16'($urandom_range(7));
			default: lo = 16'($urandom);
		endcase
		return make_ins(op, 5'($urandom), 5'($urandom), lo);
	endfunction

	task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_instruction(random_instruction());
		wait_drained();
	endtask

	// long receiver hold-off while sending, then a pause until drained and a further run of sends
	task automatic test_back_pressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 200;
		repeat (12)
			send_instruction(random_instruction());
		wait_drained();
		repeat (20)
			send_instruction(random_instruction());
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		valid_in = 1'b0;
		instruction = 32'd0;
		mismatch_count = 0;
		result_count = 0;
		sent_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		arch_pc = 8'd0;
		for (i = 0; i < 32; i++)
			arch_regs[i] = 32'd0;
		for (i = 0; i < MEM_WORDS; i++)
			arch_mem[i] = 32'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_drained();
		test_random_phase(140, 0, 0);
		test_random_phase(120, 64, 0);
		test_random_phase(120, 0, 64);
		test_random_phase(120, 24, 24);
		test_back_pressure();
		wait_drained();
		repeat (50) @(posedge clk);

		$display("Ran %0d instructions (all opcodes, memory, branches, faults) with", sent_count);
		$display("varied idling and back-pressure; %0d results checked", result_count);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_count,
				pending_results.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Timeout");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
